### design/keypad_press_classifier_macros.svh
// ----------------------------------------------------------------------------
// keypad_press_classifier_macros
// Assertion helpers shared by the keypad press classifier RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PRESS_CLASSIFIER_MACROS_SVH
`define KEYPAD_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define KPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KPC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared constants and types of the keypad press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

   localparam int KEY_COUNT   = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_W     = 16;
   localparam int THR_W       = 16;
   localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam int CSR_IDX_W   = 1;

   // key status codes
   localparam logic [1:0] KEY_IDLE = 2'd0;
   localparam logic [1:0] KEY_DOWN = 2'd1;
   localparam logic [1:0] KEY_UP   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_THR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_THR  = 1'd1;

   localparam logic [THR_W-1:0] SHORT_THR_RST = 16'd2;
   localparam logic [THR_W-1:0] LONG_THR_RST  = 16'd500;

   typedef struct packed {
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] count;
   } key_rec_type;

   localparam int REC_W = $bits(key_rec_type);

   typedef struct packed {
      key_rec_type rec;
      logic        short_hit;
      logic        long_hit;
      logic        release_hit;
   } key_upd_type;

endpackage

`default_nettype wire

### design/kpc_ram.sv
// ----------------------------------------------------------------------------
// kpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/kpc_key_unit.sv
// ----------------------------------------------------------------------------
// kpc_key_unit
// Per-key update: status/counter transition and short/long/release flags.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_key_unit (
   input  wire  kpc_pkg::key_rec_type       cur,
   input  wire  logic                       hit,
   input  wire  logic [kpc_pkg::THR_W-1:0]  short_thr,
   input  wire  logic [kpc_pkg::THR_W-1:0]  long_thr,
   output kpc_pkg::key_upd_type             upd
);
   import kpc_pkg::*;

   key_rec_type            mid;
   logic [CMP_W-1:0]       cnt_ext;
   logic                   is_down;

   always_comb begin
      mid = cur;
      if (hit) begin
         if (cur.status == KEY_DOWN) begin
            if (cur.count != '1) begin
               mid.count = cur.count + COUNT_WIDTH'(1);
            end
         end else begin
            mid.status = KEY_DOWN;
            mid.count  = '0;
         end
      end else if (cur.status == KEY_DOWN) begin
         mid.status = KEY_UP;
      end
   end

   assign cnt_ext = CMP_W'(mid.count);
   assign is_down = (mid.status == KEY_DOWN);

   always_comb begin
      upd.rec         = mid;
      upd.short_hit   = is_down && (cnt_ext > CMP_W'(short_thr));
      upd.long_hit    = is_down && (cnt_ext > CMP_W'(long_thr));
      upd.release_hit = (mid.status == KEY_UP) && (mid.count != '0);
      if (upd.release_hit) begin
         upd.rec.status = KEY_IDLE;
      end
   end

endmodule

`default_nettype wire

### design/keypad_press_classifier.sv
// ----------------------------------------------------------------------------
// keypad_press_classifier
// Press classifier for a 16-key matrix with short, long and release masks.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per scan tick, tdata = sampled pressed bits.
//   rsp channel: one beat per tick, tdata = short, long and release masks.
//   csr channel: index 0 short threshold, index 1 long threshold; always
//   ready, write only while the block is idle.
// Each tick walks the keys through the state RAM one per cycle: read,
// update, write back. The key walk runs in S_RUN, S_WAIT lets the last
// key's update finish, and S_DONE loads the result register. A new tick
// is accepted only in S_IDLE, after the masks of the previous one are
// loaded, so ticks never overlap in the walk.
// A new tick is accepted as soon as the result is registered, even while
// the previous result is still waiting on rsp_tready; the finished masks
// wait in the sequencer until the output register frees up.
// Reset: thresholds go to 2 and 500, all keys read as idle with a zero
// count (per-entry valid bits, no clearing pass), no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_press_classifier (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              req_tvalid,
   output logic                                    req_tready,
   input  wire  logic [15:0]                       req_tdata,  // [15:0] pressed_bits
   output logic                                    rsp_tvalid,
   input  wire  logic                              rsp_tready,
   output logic [47:0]                             rsp_tdata,  // [15:0] short_mask,
                                                               // [31:16] long_mask,
                                                               // [47:32] release_mask
   input  wire  logic                              csr_valid,
   output logic                                    csr_ready,
   input  wire  logic [kpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  logic [15:0]                       csr_data
);
   import kpc_pkg::*;
   `include "keypad_press_classifier_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [KEY_IDX_W-1:0] LAST_IDX = KEY_IDX_W'(KEY_COUNT - 1);

   logic [1:0]             state_ff, state_in;
   logic [KEY_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                   p1_vld_ff;
   logic [KEY_IDX_W-1:0]   p1_idx_ff;
   logic                   p1_ent_vld_ff;
   logic [KEY_COUNT-1:0]   vld_ff, vld_in;
   logic [FIELD_W-1:0]     pressed_ff;
   logic [THR_W-1:0]       short_thr_ff, short_thr_in;
   logic [THR_W-1:0]       long_thr_ff, long_thr_in;
   logic [FIELD_W-1:0]     acc_short_ff, acc_short_in;
   logic [FIELD_W-1:0]     acc_long_ff, acc_long_in;
   logic [FIELD_W-1:0]     acc_rel_ff, acc_rel_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [47:0]            rsp_data_ff;

   logic                   req_acc;
   logic                   rsp_load;
   logic                   ram_rd_en;
   logic [REC_W-1:0]       ram_rd_data;
   key_rec_type            cur_rec;
   key_upd_type            upd;
   logic [FIELD_W-1:0]     bit_sel;
   logic                   key_hit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign ram_rd_en  = (state_ff == S_RUN);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_vld_ff || rsp_tready);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   kpc_ram #(
      .WIDTH (REC_W),
      .DEPTH (KEY_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (p1_vld_ff),
      .wr_addr (p1_idx_ff),
      .wr_data (upd.rec),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // never-written entries read as idle, count zero
   always_comb begin
      if (p1_ent_vld_ff) begin
         cur_rec = key_rec_type'(ram_rd_data);
      end else begin
         cur_rec.status = KEY_IDLE;
         cur_rec.count  = '0;
      end
   end

   assign bit_sel = FIELD_W'(1) << p1_idx_ff;
   assign key_hit = |(pressed_ff & bit_sel);

   kpc_key_unit u_key_unit (
      .cur       (cur_rec),
      .hit       (key_hit),
      .short_thr (short_thr_ff),
      .long_thr  (long_thr_ff),
      .upd       (upd)
   );

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in  = S_RUN;
               rd_idx_in = '0;
            end
         end
         S_RUN: begin
            rd_idx_in = rd_idx_ff + KEY_IDX_W'(1);
            if (rd_idx_ff == LAST_IDX) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      vld_in       = vld_ff;
      acc_short_in = acc_short_ff;
      acc_long_in  = acc_long_ff;
      acc_rel_in   = acc_rel_ff;
      if (req_acc) begin
         acc_short_in = '0;
         acc_long_in  = '0;
         acc_rel_in   = '0;
      end else if (p1_vld_ff) begin
         vld_in[p1_idx_ff] = 1'b1;
         if (upd.short_hit) begin
            acc_short_in = acc_short_ff | bit_sel;
         end
         if (upd.long_hit) begin
            acc_long_in = acc_long_ff | bit_sel;
         end
         if (upd.release_hit) begin
            acc_rel_in = acc_rel_ff | bit_sel;
         end
      end
   end

   always_comb begin
      short_thr_in = short_thr_ff;
      long_thr_in  = long_thr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SHORT_THR: short_thr_in = csr_data;
            REG_LONG_THR:  long_thr_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_idx_ff    <= '0;
         p1_vld_ff    <= 1'b0;
         vld_ff       <= '0;
         short_thr_ff <= SHORT_THR_RST;
         long_thr_ff  <= LONG_THR_RST;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         p1_vld_ff    <= ram_rd_en;
         vld_ff       <= vld_in;
         short_thr_ff <= short_thr_in;
         long_thr_ff  <= long_thr_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff     <= rd_idx_ff;
      p1_ent_vld_ff <= vld_ff[rd_idx_ff];
      acc_short_ff  <= acc_short_in;
      acc_long_ff   <= acc_long_in;
      acc_rel_ff    <= acc_rel_in;
      if (req_acc) begin
         pressed_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_data_ff <= {acc_rel_ff, acc_long_ff, acc_short_ff};
      end
   end

   `KPC_ASSERT_IMP(a_accept_quiet, req_tvalid && req_tready, !p1_vld_ff && !ram_rd_en,
                   "tick accepted while a key walk is in flight")
   `KPC_ASSERT_IMP(a_no_rw_clash, p1_vld_ff && ram_rd_en, p1_idx_ff != rd_idx_ff,
                   "state RAM read and write hit the same key")
   `KPC_ASSERT_NXT(a_load_shows, rsp_load, rsp_tvalid,
                   "result load did not raise rsp_tvalid")
   `KPC_ASSERT_IMP(a_release_vs_short, rsp_tvalid, (rsp_tdata[47:32] & rsp_tdata[15:0]) == '0,
                   "key reported released and held in one beat")

endmodule

`default_nettype wire

### dv/tb_keypad_press_classifier.sv
// ----------------------------------------------------------------------------
// tb_keypad_press_classifier
// Self-checking bench for the keypad press classifier. Scan ticks go in on
// the req stream, and a local model of every key's status and hold count
// predicts the short, long and release masks of each tick, in order. The
// bench writes thresholds between phases, runs directed ticks, random
// press/hold/release sequences with noise, random gaps on both streams and
// a long rsp hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keypad_press_classifier;

   import kpc_pkg::*;

   localparam int RUN_LIMIT = 200_000;
   localparam logic [COUNT_WIDTH-1:0] HOLD_MAX = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic [15:0] release_mask;
      logic [15:0] long_mask;
      logic [15:0] short_mask;
   } key_masks_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   // scan ticks waiting for the driver, and predicted masks per accepted tick
   logic [15:0]          tick_queue[$];
   key_masks_t           mask_queue[$];

   // model state
   logic [1:0]             key_state[KEY_COUNT];
   logic [COUNT_WIDTH-1:0] key_hold[KEY_COUNT];
   logic [15:0]            short_thr;
   logic [15:0]            long_thr;

   logic req_fire = 1'b0;
   int   tick_count = 0;
   int   err_count = 0;
   int   cycle_count = 0;
   int   stall_left = 0;
   logic stall_done = 1'b0;
   logic no_gaps;

   assign no_gaps = (tick_count >= 130 && tick_count < 200);

   keypad_press_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_keypad_press_classifier: errors");
         $finish;
      end
   end

   function automatic key_masks_t classify_tick(input logic [15:0] pressed);
      key_masks_t m;
      m = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (k < 16 && pressed[k]) begin
            if (key_state[k] == KEY_DOWN) begin
               if (key_hold[k] != HOLD_MAX) key_hold[k] = key_hold[k] + COUNT_WIDTH'(1);
            end else begin
               key_state[k] = KEY_DOWN;
               key_hold[k] = '0;
            end
         end else if (key_state[k] == KEY_DOWN) begin
            key_state[k] = KEY_UP;
         end
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (k < 16) begin
            m.short_mask[k] = (key_state[k] == KEY_DOWN) && (key_hold[k] > short_thr);
            m.long_mask[k] = (key_state[k] == KEY_DOWN) && (key_hold[k] > long_thr);
            m.release_mask[k] = (key_state[k] == KEY_UP) && (key_hold[k] != '0);
         end
         if (key_state[k] == KEY_UP && key_hold[k] != '0) key_state[k] = KEY_IDLE;
      end
      return m;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         err_count++;
      end
   endfunction

   // model update, prediction and result check
   always @(posedge clock) begin : check_blk
      key_masks_t want;
      key_masks_t got;
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            key_state[k] = KEY_IDLE;
            key_hold[k] = '0;
         end
         short_thr = SHORT_THR_RST;
         long_thr = LONG_THR_RST;
         mask_queue.delete();
         req_fire <= 1'b0;
         tick_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SHORT_THR: short_thr = csr_data;
               REG_LONG_THR:  long_thr = csr_data;
               default: ;
            endcase
         end
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            mask_queue.push_back(classify_tick(req_tdata));
            tick_count <= tick_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (mask_queue.size() == 0) begin
               $display("%0t: unexpected beat, expected none actual %h", $time, rsp_tdata);
               err_count++;
            end else begin
               want = mask_queue.pop_front();
               check_field("short_mask", want.short_mask, got.short_mask);
               check_field("long_mask", want.long_mask, got.long_mask);
               check_field("release_mask", want.release_mask, got.release_mask);
            end
         end
      end
   end

   // req driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (tick_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
            req_tvalid <= 1'b1;
            req_tdata <= tick_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp receiver, with one long hold-off mid-run
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && tick_count >= 250) begin
         rsp_tready <= 1'b0;
         stall_left <= 400;
         stall_done <= 1'b1;
      end else begin
         rsp_tready <= no_gaps || $urandom_range(99) >= 34;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (tick_queue.size() != 0 || req_tvalid || mask_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(input logic [15:0] short_v, input logic [15:0] long_v,
                             input int count);
      logic [15:0] held;
      write_reg(REG_SHORT_THR, short_v);
      write_reg(REG_LONG_THR, long_v);
      held = '0;
      repeat (count) begin
         // mostly keys held across ticks with sparse changes; some noise
         if ($urandom_range(99) < 75) begin
            held = held ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
         end else begin
            case ($urandom_range(3))
               0:       held = '0;
               1:       held = '1;
               default: held = 16'($urandom);
            endcase
         end
         tick_queue.push_back(held);
      end
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: all keys, quick tap then re-press, partial release
      tick_queue = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'hAAAA, 16'h0000, 16'h0000, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                     16'hAAAA, 16'h5555, 16'h0000};
      settle();

      write_reg(REG_SHORT_THR, 16'd0);
      write_reg(REG_LONG_THR, 16'd1);
      tick_queue = '{16'h8001, 16'h8001, 16'h8001, 16'h8001, 16'h0000, 16'hFFFF,
                     16'h0000, 16'h5555};
      settle();

      run_random(16'd3, 16'd12, 100);
      run_random(16'd0, 16'd0, 100);
      run_random(16'd1, 16'hFFFF, 100);
      run_random(16'($urandom_range(6)), 16'($urandom_range(40, 4)), 100);
      run_random(16'hFFFF, 16'd5, 100);

      repeat (40) @(posedge clock);
      if (err_count == 0 && mask_queue.size() == 0) begin
         $display("tb_keypad_press_classifier: clean");
      end else begin
         $display("tb_keypad_press_classifier: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/kpc_pkg.sv
design/kpc_ram.sv
design/kpc_key_unit.sv
design/keypad_press_classifier.sv
dv/tb_keypad_press_classifier.sv
